/* design/dmdz_pkg.sv */
// Shared types and constants of the delayed motion dead-zone filter.
package dmdz_pkg;

   // Field widths
   localparam int DELTA_W = 16;
   localparam int TIME_W  = 32;

   // Configuration registers
   localparam int TIMEOUT_W   = 16;
   localparam int DEAD_ZONE_W = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE = 1'd1;

   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = 16'd80;
   localparam logic [DEAD_ZONE_W-1:0] DEAD_ZONE_RESET = 8'd2;

   // Default window depth (window holds WINDOW_DEPTH+1 motions)
   localparam int WINDOW_DEPTH_DEFAULT = 4;

   // One stored motion
   typedef struct packed {
      logic [TIME_W-1:0]         ts;
      logic signed [DELTA_W-1:0] dy;
      logic signed [DELTA_W-1:0] dx;
   } motion_type;

   // Control of one window cell
   typedef struct packed {
      logic shift;
      logic flush;
   } cell_ctrl_type;

   // Control of the running window sums
   typedef struct packed {
      logic shift;
      logic flush;
      logic drop;
   } sum_ctrl_type;

endpackage

/* design/dmdz_cell.sv */
// One window cell: holds one motion and its valid bit, shifts toward older.
module dmdz_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dmdz_pkg::cell_ctrl_type ctrl,
   input  logic                   link_valid,
   input  dmdz_pkg::motion_type   link_data,
   output logic                   valid_out,
   output dmdz_pkg::motion_type   data_out
);
   import dmdz_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   motion_type data_ff;

   // Take the neighbor's motion on a shift; a flush during a shift empties the cell
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.shift) begin
         valid_in = link_valid & ~ctrl.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= link_data;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

/* design/dmdz_sum.sv */
// Running window sums of dx and dy with the dead-zone test.
module dmdz_sum #(
   parameter int WINDOW_DEPTH = dmdz_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dmdz_pkg::sum_ctrl_type                 ctrl,
   input  logic signed [dmdz_pkg::DELTA_W-1:0]    add_dx,
   input  logic signed [dmdz_pkg::DELTA_W-1:0]    add_dy,
   input  logic signed [dmdz_pkg::DELTA_W-1:0]    drop_dx,
   input  logic signed [dmdz_pkg::DELTA_W-1:0]    drop_dy,
   input  logic [dmdz_pkg::DEAD_ZONE_W-1:0]       dead_zone,
   output logic                                   in_zone,
   output logic                                   window_empty_sum
);
   import dmdz_pkg::*;

   localparam int STORE_SIZE = WINDOW_DEPTH + 1;
   localparam int SUM_W      = DELTA_W + $clog2(STORE_SIZE);

   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic signed [SUM_W-1:0] base_x, base_y;
   logic signed [SUM_W-1:0] sub_x, sub_y;
   logic signed [SUM_W-1:0] dz_pos, dz_neg;

   // Clear on flush, drop the oldest when full, add the new motion
   always_comb begin
      base_x = ctrl.flush ? '0 : sum_x_ff;
      base_y = ctrl.flush ? '0 : sum_y_ff;
      sub_x  = ctrl.drop ? SUM_W'(drop_dx) : '0;
      sub_y  = ctrl.drop ? SUM_W'(drop_dy) : '0;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      if (ctrl.shift) begin
         sum_x_in = base_x + SUM_W'(add_dx) - sub_x;
         sum_y_in = base_y + SUM_W'(add_dy) - sub_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // Both updated sums strictly inside the dead zone
   always_comb begin
      dz_pos  = $signed({{(SUM_W-DEAD_ZONE_W){1'b0}}, dead_zone});
      dz_neg  = -dz_pos;
      in_zone = (sum_x_in < dz_pos) && (sum_x_in > dz_neg) &&
                (sum_y_in < dz_pos) && (sum_y_in > dz_neg);
   end

   assign window_empty_sum = (sum_x_ff == '0) && (sum_y_ff == '0);

endmodule

/* design/delayed_motion_dead_zone_filter.sv */
// Top level of the delayed motion dead-zone filter.
//
// Usage: motions (dx, dy, timestamp in ms) arrive on the req_ stream; each
// accepted transfer yields exactly one result on the rsp_ stream. The block
// keeps a window of up to WINDOW_DEPTH+1 motions in a row of shift cells,
// newest in cell 0. A new motion whose timestamp lies more than timeout_ms
// after the newest stored one empties the window first. The result is the
// oldest stored motion (the new one if the window was empty); while the
// window fills, the first motion repeats. When both running window sums lie
// strictly inside +/-dead_zone, dx and dy of the result are zero.
// The result is registered in the output register in the cycle after the input
// transfer. Throughput: one motion per cycle while req_tready is high, set by
// the cell shift and the running-sum update.
// Stall: req_tready follows the output register; a held result blocks the
// next transfer only while rsp_tready is low.
// Reset (synchronous): window empty, sums zero, timeout_ms = 80,
// dead_zone = 2. Configuration writes are taken on any cycle with csr_we.
module delayed_motion_dead_zone_filter #(
   parameter int WINDOW_DEPTH = dmdz_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: motion_dx[15:0], motion_dy[31:16], timestamp_ms[63:32]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,
   // rsp_tdata: out_dx[15:0], out_dy[31:16], out_timestamp_ms[63:32]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [63:0]                          rsp_tdata,
   input  logic                                 csr_we,
   input  logic [dmdz_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dmdz_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dmdz_pkg::*;

   localparam int STORE_SIZE = WINDOW_DEPTH + 1;

   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic [DEAD_ZONE_W-1:0] dead_zone_ff;

   logic            accept;
   motion_type      new_motion;
   logic [TIME_W-1:0] gap;
   logic            flush;
   logic [STORE_SIZE-1:0] cell_valid;
   logic [STORE_SIZE-1:0] eff_valid;
   logic [STORE_SIZE-1:0] oldest_hit;
   motion_type      cell_data [STORE_SIZE];
   motion_type      oldest;
   logic            full;
   logic            in_zone;
   logic            window_empty_sum;
   sum_ctrl_type    sum_ctrl;

   logic            rsp_valid_ff;
   motion_type      rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         dead_zone_ff <= DEAD_ZONE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata[TIMEOUT_W-1:0];
            CSR_DEAD_ZONE: dead_zone_ff <= csr_wdata[DEAD_ZONE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   assign new_motion.dx = $signed(req_tdata[15:0]);
   assign new_motion.dy = $signed(req_tdata[31:16]);
   assign new_motion.ts = req_tdata[63:32];

   // Empty the window on a forward gap larger than the timeout
   assign gap   = new_motion.ts - cell_data[0].ts;
   assign flush = cell_valid[0] &&
                  ($signed(gap) > $signed({{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ff}));

   // Row of window cells, newest in cell 0
   for (genvar i = 0; i < STORE_SIZE; i++) begin : g_cell
      cell_ctrl_type ctrl;
      logic          link_valid;
      motion_type    link_data;
      if (i == 0) begin : g_head
         assign ctrl.shift = accept;
         assign ctrl.flush = 1'b0;
         assign link_valid = 1'b1;
         assign link_data  = new_motion;
      end else begin : g_body
         assign ctrl.shift = accept;
         assign ctrl.flush = flush;
         assign link_valid = cell_valid[i-1];
         assign link_data  = cell_data[i-1];
      end
      dmdz_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .link_valid (link_valid),
         .link_data  (link_data),
         .valid_out  (cell_valid[i]),
         .data_out   (cell_data[i])
      );
   end

   // Locate the oldest motion left after a possible flush
   always_comb begin
      eff_valid = cell_valid & ~{STORE_SIZE{flush}};
      full      = eff_valid[STORE_SIZE-1];
      for (int i = 0; i < STORE_SIZE; i++) begin
         if (i == STORE_SIZE - 1) begin
            oldest_hit[i] = eff_valid[i];
         end else begin
            oldest_hit[i] = eff_valid[i] & ~eff_valid[i+1];
         end
      end
   end

   // One-hot select of the oldest motion; the new one when empty
   always_comb begin
      oldest = '0;
      for (int i = 0; i < STORE_SIZE; i++) begin
         oldest = oldest | (cell_data[i] & {$bits(motion_type){oldest_hit[i]}});
      end
      if (!eff_valid[0]) begin
         oldest = new_motion;
      end
   end

   assign sum_ctrl.shift = accept;
   assign sum_ctrl.flush = flush;
   assign sum_ctrl.drop  = full;

   dmdz_sum #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_sum (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (sum_ctrl),
      .add_dx           (new_motion.dx),
      .add_dy           (new_motion.dy),
      .drop_dx          (cell_data[STORE_SIZE-1].dx),
      .drop_dy          (cell_data[STORE_SIZE-1].dy),
      .dead_zone        (dead_zone_ff),
      .in_zone          (in_zone),
      .window_empty_sum (window_empty_sum)
   );

   // Output register: hold until the receiver takes the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.ts <= oldest.ts;
         rsp_data_ff.dx <= in_zone ? '0 : oldest.dx;
         rsp_data_ff.dy <= in_zone ? '0 : oldest.dy;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.ts, rsp_data_ff.dy, rsp_data_ff.dx};

   // Valid cells always form a contiguous run from cell 0
   a_valid_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + STORE_SIZE'(1)) & cell_valid) == '0)
      else $error("window cells not contiguous");

   // An accepted motion always lands in cell 0
   a_head_filled: assert property (@(posedge clock) disable iff (reset)
      accept |=> cell_valid[0])
      else $error("accepted motion not stored");

   // Every accepted transfer leaves a result in the output register
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("result missing after transfer");

   // An empty window carries zero sums
   a_empty_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (cell_valid == '0) |-> window_empty_sum)
      else $error("sums nonzero with empty window");

endmodule
